### rtl/core/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg: shared types and constants for the running median store
// Status codes, item kinds, controller states and the cell control bundle.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int VALUE_W      = 32;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_REMOVE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_REMOVED  = 2'd1,
        STAT_FULL     = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic               ins;
        logic               rem;
        logic [VALUE_W-1:0] value;
    } cell_ctl_t;

endpackage

### rtl/core/rms_in_if.sv
// ----------------------------------------------------------------------------
// rms_in_if: input channel of the running median store
// Carries one insert or remove beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rms_in_if;
    logic        valid;
    logic        ready;
    logic [0:0]  kind;
    logic [31:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

### rtl/core/rms_out_if.sv
// ----------------------------------------------------------------------------
// rms_out_if: result channel of the running median store
// Carries one result beat (removed median and status) per input beat.
// ----------------------------------------------------------------------------
interface rms_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] median_out;
    logic [1:0]  status;

    modport source (output valid, output median_out, output status, input ready);
    modport sink   (input valid, input median_out, input status, output ready);
endinterface

### rtl/core/rms_cell.sv
// ----------------------------------------------------------------------------
// rms_cell: one slot of the sorted store
// Holds one entry, compares it with the insert value and shifts with its
// neighbors: right on insert, left on median removal.
// ----------------------------------------------------------------------------
module rms_cell #(
    parameter int CW  = 7,
    parameter int IDX = 0
) (
    input  logic                        clk,
    input  rms_pkg::cell_ctl_t          ctl,
    input  logic [CW-1:0]               count,
    input  logic [CW-1:0]               mid_idx,
    input  logic [rms_pkg::VALUE_W-1:0] left_entry,
    input  logic                        left_gt,
    input  logic [rms_pkg::VALUE_W-1:0] right_entry,
    output logic [rms_pkg::VALUE_W-1:0] entry,
    output logic                        gt,
    output logic [rms_pkg::VALUE_W-1:0] tap
);
    import rms_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;

    // occupied and larger than the value: this slot moves up on insert
    assign gt    = (IDX_C < count) && (entry_reg > ctl.value);
    assign entry = entry_reg;
    assign tap   = (IDX_C == mid_idx) ? entry_reg : '0;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins)
        begin
            if (left_gt)
                entry_next = left_entry;
            else if (gt || (IDX_C == count))
                entry_next = ctl.value;
        end
        else if (ctl.rem)
        begin
            if (IDX_C >= mid_idx)
                entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

### rtl/core/running_median_store_core.sv
// ----------------------------------------------------------------------------
// running_median_store_core: sorted store with insert and remove-median
// The beat is registered, then its result once the result register is free;
// the cell row shifts with it. No new beat is accepted until the item is done.
// Reset clears the entry count, the controller and the result valid;
// entry slots are not cleared, only slots below the count are read.
// ----------------------------------------------------------------------------
module running_median_store_core #(
    parameter int CAPACITY = rms_pkg::DEF_CAPACITY
) (
    input  logic      clk,
    input  logic      rst_n,
    rms_in_if.sink    in,
    rms_out_if.source out
);
    import rms_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t             state_reg, state_next;
    logic               kind_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] med_reg, med_next;
    status_t            status_reg, status_next;

    cell_ctl_t          ctl;
    logic [CW-1:0]      mid_idx;
    logic [VALUE_W-1:0] median_sel;

    logic [VALUE_W-1:0] entry_w [CAPACITY];
    logic               gt_w    [CAPACITY];
    logic [VALUE_W-1:0] tap_w   [CAPACITY];

    logic accept;
    logic is_insert;
    logic is_full;
    logic is_empty;

    assign accept    = in.valid && in.ready;
    assign in.ready  = (state_reg == ST_IDLE);
    assign is_insert = (kind_reg == KIND_INSERT);
    assign is_full   = (count_reg == CAP_C);
    assign is_empty  = (count_reg == '0);
    assign mid_idx   = (count_reg - CW'(1)) >> 1;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] l_entry;
            logic               l_gt;
            logic [VALUE_W-1:0] r_entry;

            if (gi == 0)
            begin : g_first
                assign l_entry = '0;
                assign l_gt    = 1'b0;
            end
            else
            begin : g_mid
                assign l_entry = entry_w[gi-1];
                assign l_gt    = gt_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign r_entry = '0;
            end
            else
            begin : g_inner
                assign r_entry = entry_w[gi+1];
            end

            rms_cell #(
                .CW  (CW),
                .IDX (gi)
            ) u_cell (
                .clk         (clk),
                .ctl         (ctl),
                .count       (count_reg),
                .mid_idx     (mid_idx),
                .left_entry  (l_entry),
                .left_gt     (l_gt),
                .right_entry (r_entry),
                .entry       (entry_w[gi]),
                .gt          (gt_w[gi]),
                .tap         (tap_w[gi])
            );
        end
    endgenerate

    // only the median slot drives its tap
    always_comb
    begin
        median_sel = '0;
        for (int i = 0; i < CAPACITY; i++)
            median_sel = median_sel | tap_w[i];
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        med_next       = med_reg;
        status_next    = status_reg;
        ctl.ins        = 1'b0;
        ctl.rem        = 1'b0;
        ctl.value      = value_reg;

        // drop the result beat once taken
        if (out_valid_reg && out.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                // hold until the result register is free
                if (!out_valid_reg || out.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    med_next       = '0;
                    if (is_insert)
                    begin
                        if (is_full)
                            status_next = STAT_FULL;
                        else
                        begin
                            ctl.ins     = 1'b1;
                            count_next  = count_reg + CW'(1);
                            status_next = STAT_INSERTED;
                        end
                    end
                    else
                    begin
                        if (is_empty)
                            status_next = STAT_EMPTY;
                        else
                        begin
                            ctl.rem     = 1'b1;
                            count_next  = count_reg - CW'(1);
                            med_next    = median_sel;
                            status_next = STAT_REMOVED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= in.kind;
            value_reg <= in.value;
        end
        med_reg    <= med_next;
        status_reg <= status_next;
    end

    assign out.valid      = out_valid_reg;
    assign out.median_out = med_reg;
    assign out.status     = status_reg;

endmodule

### tb/running_median_store_checker.sv
// ----------------------------------------------------------------------------
// running_median_store_checker: result predictor and comparator
// Watches the input and result channels, keeps its own sorted copy of the
// store, works out the result of every accepted input beat and compares each
// accepted result beat field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module running_median_store_checker #(
    parameter int CAPACITY = rms_pkg::DEF_CAPACITY
) (
    input  logic clk,
    input  logic rst_n,
    rms_in_if    in_ch,
    rms_out_if   out_ch,
    output int   failures,
    output int   awaiting
);
    import rms_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] median;
        status_t            status;
    } result_t;

    logic [VALUE_W-1:0] sorted_vals [CAPACITY];
    int                 held_count;
    result_t            awaited_results [$];

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        failures++;
        $display("%0t: %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    // Apply one beat to the shadow store and return what the block must answer.
    task automatic apply_beat(input kind_t kind, input logic [VALUE_W-1:0] value,
                              output result_t res);
        int pos;
        int mid;
        res.median = '0;
        if (kind == KIND_INSERT)
        begin
            if (held_count >= CAPACITY)
            begin
                res.status = STAT_FULL;
            end
            else
            begin
                // equal values land after those already held
                pos = held_count;
                while (pos > 0 && sorted_vals[pos-1] > value)
                begin
                    sorted_vals[pos] = sorted_vals[pos-1];
                    pos--;
                end
                sorted_vals[pos] = value;
                held_count++;
                res.status = STAT_INSERTED;
            end
        end
        else if (held_count == 0)
        begin
            res.status = STAT_EMPTY;
        end
        else
        begin
            // lower middle entry on an even count
            mid = (held_count - 1) / 2;
            res.median = sorted_vals[mid];
            for (int i = mid; i + 1 < held_count; i++)
                sorted_vals[i] = sorted_vals[i+1];
            held_count--;
            res.status = STAT_REMOVED;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            held_count = 0;
            awaited_results.delete();
            awaiting = 0;
        end
        else
        begin
            // check the result beat first: it cannot belong to a beat accepted now
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    report_mismatch("result beat with nothing awaited",
                                    out_ch.median_out, '0);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (out_ch.status !== want.status)
                        report_mismatch("status", {30'b0, out_ch.status},
                                        {30'b0, want.status});
                    if (out_ch.median_out !== want.median)
                        report_mismatch("median_out", out_ch.median_out, want.median);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                apply_beat(kind_t'(in_ch.kind), in_ch.value, want);
                awaited_results.insert(awaited_results.size(), want);
            end
            awaiting = awaited_results.size();
        end
    end

endmodule

### tb/running_median_store_core_tb.sv
// ----------------------------------------------------------------------------
// running_median_store_core_tb: testbench top for the running median store
// Drives directed and random insert/remove beats with random gaps on both
// channels, fills and drains the store to its limits, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module running_median_store_core_tb;
    import rms_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int TARGET_ITEMS = 700;
    localparam int IDLE_LIMIT   = 4000;

    logic clk;
    logic rst_n;
    int   failures;
    int   awaiting;
    int   items_sent;
    int   held;
    bit   quiet;
    int   idle_cycles;

    rms_in_if  in_ch ();
    rms_out_if out_ch ();

    running_median_store_core #(.CAPACITY(CAPACITY)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch)
    );

    running_median_store_checker #(.CAPACITY(CAPACITY)) median_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .failures (failures),
        .awaiting (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones; none at all in a quiet stretch.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(0, 7);
            3:       return 32'h8000_0000 | $urandom_range(0, 3);
            default: return $urandom();
        endcase
    endfunction

    // Entered and left on a falling edge; valid stays high into the next beat.
    task automatic send_beat(input kind_t kind, input logic [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
        items_sent++;
        if (kind == KIND_INSERT && held < CAPACITY)
            held++;
        else if (kind == KIND_REMOVE && held > 0)
            held--;
    endtask

    // Hold the sender until every awaited result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (awaiting != 0);
    endtask

    // Result side: random stalls, lowered only on falling edges.
    initial
    begin
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (!rst_n) begin
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Stop the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        int first_phase;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.kind  = KIND_INSERT;
        in_ch.value = '0;
        items_sent  = 0;
        held        = 0;
        quiet       = 1'b0;
        idle_cycles = 0;
        first_phase = 1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty remove, extremes, duplicates, odd and even medians
        send_beat(KIND_REMOVE, 32'h1234_5678);
        send_beat(KIND_INSERT, 32'h0000_0000);
        send_beat(KIND_INSERT, 32'hFFFF_FFFF);
        send_beat(KIND_INSERT, 32'h8000_0000);
        send_beat(KIND_INSERT, 32'h7FFF_FFFF);
        send_beat(KIND_INSERT, 32'h0000_0005);
        send_beat(KIND_INSERT, 32'h0000_0005);
        send_beat(KIND_INSERT, 32'h0000_0001);
        send_beat(KIND_REMOVE, 32'h0000_0000);
        send_beat(KIND_REMOVE, 32'hFFFF_FFFF);
        send_beat(KIND_INSERT, 32'hAAAA_AAAA);
        send_beat(KIND_INSERT, 32'h5555_5555);
        send_beat(KIND_INSERT, 32'h0000_0000);
        while (held > 0)
            send_beat(KIND_REMOVE, pick_value());
        send_beat(KIND_REMOVE, 32'hFFFF_FFFF);

        while (items_sent < TARGET_ITEMS) begin
            quiet = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 3))
                0, 1: begin
                    repeat (40)
                        send_beat(kind_t'($urandom_range(0, 1)), pick_value());
                end
                2: begin
                    // fill to the limit, push a few dropped inserts, then mix
                    while (held < CAPACITY)
                        send_beat(KIND_INSERT, pick_value());
                    repeat ($urandom_range(1, 4))
                        send_beat(KIND_INSERT, pick_value());
                    repeat ($urandom_range(0, CAPACITY))
                        send_beat(kind_t'($urandom_range(0, 1)), pick_value());
                end
                default: begin
                    while (held > 0)
                        send_beat(KIND_REMOVE, pick_value());
                    repeat ($urandom_range(1, 3))
                        send_beat(KIND_REMOVE, pick_value());
                end
            endcase
            if (first_phase != 0 || $urandom_range(0, 3) == 0)
                drain_results();
            first_phase = 0;
        end

        quiet = 1'b0;
        drain_results();
        repeat (8) @(negedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
